>>> design/three_lead_rms_combiner_unit_macros.svh
// Assertion helpers shared by the combiner RTL
`ifndef THREE_LEAD_RMS_COMBINER_UNIT_MACROS_SVH
`define THREE_LEAD_RMS_COMBINER_UNIT_MACROS_SVH

// same-cycle implication, idle during reset
`define TLRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, idle during reset
`define TLRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/tlrc_pkg.sv
package tlrc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SCALE_W  = 16;
   localparam int VAL_W    = SAMPLE_W + 1;          // lead + offset
   localparam int MAG_W    = SAMPLE_W + 1;          // |lead + offset| <= 65536
   localparam int SQ_W     = 2 * SAMPLE_W + 1;      // square <= 2^32
   localparam int SUM_W    = SQ_W + 1;              // three squares < 2^34
   localparam int ROOT_W   = SUM_W / 2;
   localparam int REM_W    = ROOT_W + 3;
   localparam int PROD_W   = ROOT_W + SCALE_W;
   localparam int Q_SHIFT  = 14;
   localparam int SCALED_W = PROD_W - Q_SHIFT;
   localparam int RES_W    = SCALED_W + 2;

   localparam int NUM_LEADS = 3;

   localparam logic [SCALE_W-1:0] NORM_SCALE_RESET = SCALE_W'(9459);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_OFFSET  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_SCALE = 1'b1;

   // pipeline stage positions
   localparam int STG_MAG   = 0;
   localparam int STG_SQ    = 1;
   localparam int STG_SUM   = 2;
   localparam int STG_ROOT0 = 3;
   localparam int STG_PROD  = STG_ROOT0 + ROOT_W;
   localparam int STG_OUT   = STG_PROD + 1;
   localparam int NSTG      = STG_OUT + 1;

   localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(32767);
   localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(32768);

   typedef struct packed {
      logic load_mag;
      logic load_sq;
   } lane_ctl_type;

endpackage

>>> design/tlrc_lane.sv
module tlrc_lane (
   input  logic                                  clock,
   input  tlrc_pkg::lane_ctl_type                ctl,
   input  logic signed [tlrc_pkg::SAMPLE_W-1:0]  lead,
   input  logic signed [tlrc_pkg::SAMPLE_W-1:0]  dc_offset,
   output logic        [tlrc_pkg::SQ_W-1:0]      square
);
   import tlrc_pkg::*;

   logic signed [VAL_W:0]     sum_wide;
   logic signed [VAL_W:0]     abs_wide;
   logic        [MAG_W-1:0]   mag_in, mag_ff;
   logic        [2*MAG_W-1:0] sq_full;
   logic        [SQ_W-1:0]    sq_in, sq_ff;

   always_comb begin
      sum_wide = (VAL_W+1)'(lead) + (VAL_W+1)'(dc_offset);
      abs_wide = sum_wide[VAL_W] ? -sum_wide : sum_wide;
      mag_in   = abs_wide[MAG_W-1:0];
      sq_full  = mag_ff * mag_ff;
      sq_in    = sq_full[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mag) begin
         mag_ff <= mag_in;
      end
      if (ctl.load_sq) begin
         sq_ff <= sq_in;
      end
   end

   assign square = sq_ff;

endmodule

>>> design/tlrc_sqrt_step.sv
module tlrc_sqrt_step (
   input  logic                          clock,
   input  logic                          load,
   input  logic [tlrc_pkg::SUM_W-1:0]    x_val,
   input  logic [tlrc_pkg::REM_W-1:0]    rem_val,
   input  logic [tlrc_pkg::ROOT_W-1:0]   root_val,
   output logic [tlrc_pkg::SUM_W-1:0]    x_out,
   output logic [tlrc_pkg::REM_W-1:0]    rem_out,
   output logic [tlrc_pkg::ROOT_W-1:0]   root_out
);
   import tlrc_pkg::*;

   logic [REM_W-1:0]  rem_sh, trial;
   logic              fits;
   logic [SUM_W-1:0]  x_in, x_ff;
   logic [REM_W-1:0]  rem_in, rem_ff;
   logic [ROOT_W-1:0] root_in, root_ff;

   // one result bit: bring down two radicand bits, try (root<<2)|1
   always_comb begin
      rem_sh  = {rem_val[REM_W-3:0], x_val[SUM_W-1:SUM_W-2]};
      trial   = REM_W'({root_val, 2'b01});
      fits    = (rem_sh >= trial);
      rem_in  = fits ? (rem_sh - trial) : rem_sh;
      root_in = {root_val[ROOT_W-2:0], fits};
      x_in    = {x_val[SUM_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign x_out    = x_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

>>> design/three_lead_rms_combiner_unit.sv
// Throughput: one beat per cycle unless the pipeline is full and rsp_ready is low;
// 3 parallel square lanes, then a 17-stage
// one-bit-per-stage square root, a scale multiply and a saturating output register.
// Bubbles collapse, so req beats are taken while a result waits for rsp_ready, as long as any stage is free.
// Reset (synchronous): pipeline emptied, dc_offset = 0, norm_scale = 9459.
module three_lead_rms_combiner_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tlrc_pkg::SAMPLE_W-1:0]  req_lead_first,
   input  logic signed [tlrc_pkg::SAMPLE_W-1:0]  req_lead_second,
   input  logic signed [tlrc_pkg::SAMPLE_W-1:0]  req_lead_third,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tlrc_pkg::SAMPLE_W-1:0]  rsp_combined_sample,
   input  logic                                  csr_we,
   input  logic        [tlrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [tlrc_pkg::SAMPLE_W-1:0]  csr_wdata
);
   import tlrc_pkg::*;

`include "three_lead_rms_combiner_unit_macros.svh"

   logic signed [SAMPLE_W-1:0] dc_offset_ff, dc_offset_in;
   logic        [SCALE_W-1:0]  norm_scale_ff, norm_scale_in;

   logic [NSTG-1:0] valid_ff, valid_in, load;

   logic signed [SAMPLE_W-1:0] lead [NUM_LEADS];
   logic        [SQ_W-1:0]     square [NUM_LEADS];
   lane_ctl_type               lane_ctl;

   logic [SUM_W-1:0]  sum_in, sum_ff;
   logic [SUM_W-1:0]  sq_x    [ROOT_W+1];
   logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
   logic [ROOT_W-1:0] sq_root [ROOT_W+1];

   logic [PROD_W-1:0]          prod_in, prod_ff;
   logic [SCALED_W-1:0]        scaled;
   logic signed [RES_W-1:0]    diff;
   logic signed [SAMPLE_W-1:0] out_in, out_ff;

   // config registers
   always_comb begin
      dc_offset_in  = dc_offset_ff;
      norm_scale_in = norm_scale_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DC_OFFSET:  dc_offset_in  = csr_wdata;
            CSR_NORM_SCALE: norm_scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_offset_ff  <= '0;
         norm_scale_ff <= NORM_SCALE_RESET;
      end else begin
         dc_offset_ff  <= dc_offset_in;
         norm_scale_ff <= norm_scale_in;
      end
   end

   // a stage may load when rsp_ready is high or any stage from it to the output is free
   for (genvar s = 0; s < NSTG; s++) begin : g_ctl
      assign load[s]     = rsp_ready || !(&valid_ff[NSTG-1:s]);
      if (s == 0) begin : g_first
         assign valid_in[s] = load[s] ? req_valid : valid_ff[s];
      end else begin : g_rest
         assign valid_in[s] = load[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[STG_MAG];

   // lanes
   assign lead[0] = req_lead_first;
   assign lead[1] = req_lead_second;
   assign lead[2] = req_lead_third;

   assign lane_ctl.load_mag = load[STG_MAG];
   assign lane_ctl.load_sq  = load[STG_SQ];

   for (genvar l = 0; l < NUM_LEADS; l++) begin : g_lane
      tlrc_lane u_lane (
         .clock     (clock),
         .ctl       (lane_ctl),
         .lead      (lead[l]),
         .dc_offset (dc_offset_ff),
         .square    (square[l])
      );
   end

   // merge the lanes
   assign sum_in = SUM_W'(square[0]) + SUM_W'(square[1]) + SUM_W'(square[2]);

   always_ff @(posedge clock) begin
      if (load[STG_SUM]) begin
         sum_ff <= sum_in;
      end
   end

   // square root, one bit per stage
   assign sq_x[0]    = sum_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      tlrc_sqrt_step u_step (
         .clock    (clock),
         .load     (load[STG_ROOT0+k]),
         .x_val    (sq_x[k]),
         .rem_val  (sq_rem[k]),
         .root_val (sq_root[k]),
         .x_out    (sq_x[k+1]),
         .rem_out  (sq_rem[k+1]),
         .root_out (sq_root[k+1])
      );
   end

   // scale
   assign prod_in = sq_root[ROOT_W] * norm_scale_ff;

   always_ff @(posedge clock) begin
      if (load[STG_PROD]) begin
         prod_ff <= prod_in;
      end
   end

   // remove offset and saturate
   always_comb begin
      scaled = prod_ff[PROD_W-1:Q_SHIFT];
      diff   = signed'(RES_W'(scaled)) - RES_W'(dc_offset_ff);
      if (diff > SAT_MAX) begin
         out_in = SAMPLE_W'(SAT_MAX);
      end else if (diff < SAT_MIN) begin
         out_in = SAMPLE_W'(SAT_MIN);
      end else begin
         out_in = diff[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[STG_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid           = valid_ff[STG_OUT];
   assign rsp_combined_sample = out_ff;

   `TLRC_ASSERT_NOW(a_full_stall, clock, reset, (&valid_ff) && !rsp_ready, !req_ready, "full pipe must refuse req")
   `TLRC_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, valid_ff[STG_MAG], "accepted beat lost at entry")
   `TLRC_ASSERT_NEXT(a_scale_reset, clock, 1'b0, reset, norm_scale_ff == NORM_SCALE_RESET && valid_ff == '0, "reset state wrong")

endmodule
